[rtl/btsg_pkg.sv]
// btsg_pkg: types, constants and byte classifiers for the bearer token shape guard
// no dependencies; imported by bearer_token_shape_guard
package btsg_pkg;

    localparam int unsigned CFG_W   = 16;
    localparam int unsigned COUNT_W = 17;

    localparam logic [CFG_W-1:0]   MAX_TOKEN_RESET = 16'd8192;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;

    localparam logic [7:0] BYTE_SP      = 8'h20;
    localparam logic [7:0] BYTE_HT      = 8'h09;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_LEAD_C2 = 8'hC2;
    localparam logic [7:0] BYTE_NEL     = 8'h85;
    localparam logic [7:0] BYTE_NBSP    = 8'hA0;
    localparam logic [7:0] BYTE_DOT     = 8'h2E;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;
    localparam logic [7:0] BYTE_DIGIT_0 = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_9 = 8'h39;
    localparam logic [7:0] BYTE_USCORE  = 8'h5F;
    localparam logic [7:0] BYTE_DASH    = 8'h2D;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SEG1  = 3'd1,
        PH_DOT1  = 3'd2,
        PH_SEG2  = 3'd3,
        PH_SEG3  = 3'd4,
        PH_TAIL  = 3'd5,
        PH_NOJWS = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CAUSE_PASS  = 2'd0,
        CAUSE_EMPTY = 2'd1,
        CAUSE_LONG  = 2'd2,
        CAUSE_JWS   = 2'd3
    } t_cause;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       last_byte;
        logic       empty_token;
    } t_tok_in;

    typedef struct packed {
        logic       refuse;
        logic [1:0] refuse_cause;
    } t_res_out;

    function automatic logic is_ws1(input logic [7:0] b);
        return (b == BYTE_SP) || ((b >= BYTE_HT) && (b <= BYTE_CR));
    endfunction

    function automatic logic is_pair_tail(input logic [7:0] b);
        return (b == BYTE_NEL) || (b == BYTE_NBSP);
    endfunction

    function automatic logic is_url_char(input logic [7:0] b);
        return ((b >= BYTE_UPPER_A) && (b <= BYTE_UPPER_Z)) ||
               ((b >= BYTE_LOWER_A) && (b <= BYTE_LOWER_Z)) ||
               ((b >= BYTE_DIGIT_0) && (b <= BYTE_DIGIT_9)) ||
               (b == BYTE_USCORE) || (b == BYTE_DASH);
    endfunction

endpackage

[rtl/bearer_token_shape_guard.sv]
// bearer_token_shape_guard: top level, trims a streamed credential and flags jws-shaped cores
// depends on btsg_pkg
//
// Bytes of one credential enter one per transaction on the i_tok channel, the final one
// with last_byte set; a zero-length credential is one transaction with empty_token set.
// Leading and trailing whitespace (09-0D, 20, and the pairs C2 85 / C2 A0) is trimmed and
// the core is checked against three dot-separated base64url segments, the third possibly
// empty. Exactly one verdict leaves on o_res per credential, on its last byte or empty mark:
// refuse_cause 1 empty after trim, 2 raw length above max_token_bytes, 3 jws-shaped, 0 pass.
// The block takes one byte every cycle while o_res is drained; each byte sits in the input
// register, and its verdict, set by the one-byte phase update, in the result register (o_res).
// A verdict held by a low i_res_ready stalls the next verdict byte. max_token_bytes resets
// to 8192; the user must write it via i_cfg_we / i_cfg_wdata only while idle (not enforced).
module bearer_token_shape_guard (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [btsg_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_tok_valid,
    output logic                             o_tok_ready,
    input  btsg_pkg::t_tok_in                i_tok,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output btsg_pkg::t_res_out               o_res
);
    import btsg_pkg::*;

    logic [CFG_W-1:0]   r_max;
    logic               r_in_valid;
    t_tok_in            r_in;
    t_phase             r_phase, n_phase;
    logic               r_pend, n_pend;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_res_valid;
    t_res_out           r_res;
    t_cause             cause;
    logic               has_result;
    logic               out_free;
    logic               s1_go;

    assign out_free    = !r_res_valid || i_res_ready;
    assign has_result  = r_in.empty_token || r_in.last_byte;
    assign s1_go       = r_in_valid && (!has_result || out_free);
    assign o_tok_ready = !r_in_valid || s1_go;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // next phase
    always_comb begin
        n_pend  = 1'b0;
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + {{(COUNT_W-1){1'b0}}, 1'b1};
        unique case (r_phase)
            PH_LEAD, PH_TAIL: begin
                if (r_pend) begin
                    n_phase = is_pair_tail(r_in.token_byte) ? r_phase : PH_NOJWS;
                end else if (is_ws1(r_in.token_byte)) begin
                    n_phase = r_phase;
                end else if (r_in.token_byte == BYTE_LEAD_C2) begin
                    n_phase = r_phase;
                    n_pend  = 1'b1;
                end else if (r_phase == PH_LEAD && is_url_char(r_in.token_byte)) begin
                    n_phase = PH_SEG1;
                end else begin
                    n_phase = PH_NOJWS;
                end
            end
            PH_SEG1: begin
                if (is_url_char(r_in.token_byte)) begin
                    n_phase = PH_SEG1;
                end else begin
                    n_phase = (r_in.token_byte == BYTE_DOT) ? PH_DOT1 : PH_NOJWS;
                end
            end
            PH_DOT1: begin
                n_phase = is_url_char(r_in.token_byte) ? PH_SEG2 : PH_NOJWS;
            end
            PH_SEG2: begin
                if (is_url_char(r_in.token_byte)) begin
                    n_phase = PH_SEG2;
                end else begin
                    n_phase = (r_in.token_byte == BYTE_DOT) ? PH_SEG3 : PH_NOJWS;
                end
            end
            PH_SEG3: begin
                if (is_url_char(r_in.token_byte)) begin
                    n_phase = PH_SEG3;
                end else if (is_ws1(r_in.token_byte)) begin
                    n_phase = PH_TAIL;
                end else if (r_in.token_byte == BYTE_LEAD_C2) begin
                    n_phase = PH_TAIL;
                    n_pend  = 1'b1;
                end else begin
                    n_phase = PH_NOJWS;
                end
            end
            default: begin
                n_phase = PH_NOJWS;
            end
        endcase
    end

    // verdict
    always_comb begin
        if (r_in.empty_token) begin
            cause = CAUSE_EMPTY;
        end else if (n_phase == PH_LEAD && !n_pend) begin
            cause = CAUSE_EMPTY;
        end else if (n_count > {1'b0, r_max}) begin
            cause = CAUSE_LONG;
        end else if (n_phase == PH_SEG3 || (n_phase == PH_TAIL && !n_pend)) begin
            cause = CAUSE_JWS;
        end else begin
            cause = CAUSE_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MAX_TOKEN_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_LEAD;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (o_tok_ready) begin
                r_in_valid <= i_tok_valid;
            end
            if (s1_go) begin
                if (has_result) begin
                    r_phase <= PH_LEAD;
                    r_pend  <= 1'b0;
                    r_count <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_pend  <= n_pend;
                    r_count <= n_count;
                end
            end
            if (s1_go && has_result) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_ready && i_tok_valid) begin
            r_in <= i_tok;
        end
        if (s1_go && has_result) begin
            r_res.refuse       <= (cause != CAUSE_PASS);
            r_res.refuse_cause <= cause;
        end
    end

`ifndef SYNTHESIS
    a_rearm_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && has_result |=> r_phase == PH_LEAD && !r_pend && r_count == '0)
        else $error("state not rearmed after verdict");

    a_pend_only_in_ws: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_phase == PH_LEAD || r_phase == PH_TAIL))
        else $error("pending lead byte outside whitespace phase");

    a_refuse_matches_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.refuse == (o_res.refuse_cause != CAUSE_PASS)))
        else $error("refuse flag disagrees with cause");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> r_res_valid && $stable(r_res))
        else $error("waiting result lost or changed");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking testbench for bearer_token_shape_guard, streams credentials byte by byte
// and checks each verdict against an internal shape predictor; depends on btsg_pkg and the rtl
module tb;
    import btsg_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     SETTLE_CYC  = 4;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_tok_valid = 1'b0;
    logic             o_tok_ready;
    t_tok_in          i_tok       = '0;
    logic             o_res_valid;
    logic             i_res_ready = 1'b0;
    t_res_out         o_res;

    // shape predictor state
    t_phase             shape_ph = PH_LEAD;
    logic               lead_c2  = 1'b0;
    logic [COUNT_W-1:0] raw_len  = '0;
    logic [CFG_W-1:0]   len_cap  = MAX_TOKEN_RESET;

    t_res_out verdict_q[$];
    t_byte_q  cred_buf;

    int     mism_cnt      = 0;
    int     src_idle_pct  = 0;
    int     sink_idle_pct = 0;
    int     hold_cycles   = 0;
    int     tok_sent      = 0;
    longint cycle_cnt     = 0;

    bearer_token_shape_guard dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok_valid (i_tok_valid),
        .o_tok_ready (o_tok_ready),
        .i_tok       (i_tok),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic logic blank_byte(input logic [7:0] b);
        return (b == BYTE_SP) || ((b >= BYTE_HT) && (b <= BYTE_CR));
    endfunction

    function automatic logic pair_second(input logic [7:0] b);
        return (b == BYTE_NEL) || (b == BYTE_NBSP);
    endfunction

    function automatic logic url_char(input logic [7:0] b);
        return ((b >= BYTE_UPPER_A) && (b <= BYTE_UPPER_Z)) ||
               ((b >= BYTE_LOWER_A) && (b <= BYTE_LOWER_Z)) ||
               ((b >= BYTE_DIGIT_0) && (b <= BYTE_DIGIT_9)) ||
               (b == BYTE_USCORE) || (b == BYTE_DASH);
    endfunction

    function automatic void shape_rearm();
        shape_ph = PH_LEAD;
        lead_c2  = 1'b0;
        raw_len  = '0;
    endfunction

    function automatic void predict_verdict(input t_tok_in t);
        logic [7:0] b;
        t_cause     cause;
        t_res_out   r;
        b = t.token_byte;
        if (t.empty_token) begin
            shape_rearm();
            r.refuse       = 1'b1;
            r.refuse_cause = CAUSE_EMPTY;
            verdict_q.push_back(r);
            return;
        end
        if (raw_len != COUNT_MAX)
            raw_len++;
        case (shape_ph)
            PH_LEAD, PH_TAIL: begin
                if (lead_c2) begin
                    lead_c2 = 1'b0;
                    if (!pair_second(b))
                        shape_ph = PH_NOJWS;
                end else if (b == BYTE_LEAD_C2) begin
                    lead_c2 = 1'b1;
                end else if (!blank_byte(b)) begin
                    shape_ph = (shape_ph == PH_LEAD && url_char(b)) ? PH_SEG1 : PH_NOJWS;
                end
            end
            PH_SEG1: begin
                if (!url_char(b))
                    shape_ph = (b == BYTE_DOT) ? PH_DOT1 : PH_NOJWS;
            end
            PH_DOT1: begin
                shape_ph = url_char(b) ? PH_SEG2 : PH_NOJWS;
            end
            PH_SEG2: begin
                if (!url_char(b))
                    shape_ph = (b == BYTE_DOT) ? PH_SEG3 : PH_NOJWS;
            end
            PH_SEG3: begin
                if (blank_byte(b)) begin
                    shape_ph = PH_TAIL;
                end else if (b == BYTE_LEAD_C2) begin
                    lead_c2  = 1'b1;
                    shape_ph = PH_TAIL;
                end else if (!url_char(b)) begin
                    shape_ph = PH_NOJWS;
                end
            end
            default: begin
                lead_c2  = 1'b0;
                shape_ph = PH_NOJWS;
            end
        endcase
        if (shape_ph != PH_LEAD && shape_ph != PH_TAIL)
            lead_c2 = 1'b0;
        if (!t.last_byte)
            return;
        if (shape_ph == PH_LEAD && !lead_c2)
            cause = CAUSE_EMPTY;
        else if (raw_len > {1'b0, len_cap})
            cause = CAUSE_LONG;
        else if (shape_ph == PH_SEG3 || (shape_ph == PH_TAIL && !lead_c2))
            cause = CAUSE_JWS;
        else
            cause = CAUSE_PASS;
        shape_rearm();
        r.refuse       = (cause != CAUSE_PASS);
        r.refuse_cause = cause;
        verdict_q.push_back(r);
    endfunction

    function automatic void log_mismatch(input string what, input t_res_out want);
        mism_cnt++;
        if (mism_cnt <= 10)
            $display("mismatch %0d at cycle %0d: %s exp refuse=%0b cause=%0d got refuse=%0b cause=%0d",
                     mism_cnt, cycle_cnt, what, want.refuse, want.refuse_cause,
                     o_res.refuse, o_res.refuse_cause);
    endfunction

    // verdict checker
    always @(posedge i_clk) begin
        t_res_out want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (verdict_q.size() == 0) begin
                want = '0;
                log_mismatch("unexpected verdict", want);
            end else begin
                want = verdict_q.pop_front();
                if (o_res.refuse !== want.refuse || o_res.refuse_cause !== want.refuse_cause)
                    log_mismatch("wrong verdict", want);
            end
        end
    end

    task automatic send_tok(input logic [7:0] b, input logic last, input logic empty);
        t_tok_in t;
        t.token_byte  = b;
        t.last_byte   = last;
        t.empty_token = empty;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_tok_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_tok       <= t;
        i_tok_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_tok_ready)
            @(posedge i_clk);
        predict_verdict(t);
        tok_sent++;
    endtask

    task automatic send_cred();
        if (cred_buf.size() == 0) begin
            send_tok(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            for (int i = 0; i < cred_buf.size(); i++)
                send_tok(cred_buf[i], (i == cred_buf.size() - 1), 1'b0);
        end
    endtask

    task automatic send_text(input string s);
        cred_buf = {};
        for (int i = 0; i < s.len(); i++)
            cred_buf.push_back(s[i]);
        send_cred();
    endtask

    // jws-shaped credential of n raw bytes: a...a.b.c
    task automatic send_long(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case (n - 1 - i)
                3, 1:    b = BYTE_DOT;
                2:       b = "b";
                0:       b = "c";
                default: b = "a";
            endcase
            send_tok(b, (i == n - 1), 1'b0);
        end
    endtask

    task automatic wait_drain();
        i_tok_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_cap = v;
    endtask

    function automatic void push_blank();
        case ($urandom_range(0, 7))
            6: begin
                cred_buf.push_back(BYTE_LEAD_C2);
                cred_buf.push_back(BYTE_NEL);
            end
            7: begin
                cred_buf.push_back(BYTE_LEAD_C2);
                cred_buf.push_back(BYTE_NBSP);
            end
            5:       cred_buf.push_back(BYTE_SP);
            default: cred_buf.push_back(8'(BYTE_HT + $urandom_range(0, 4)));
        endcase
    endfunction

    function automatic void push_segment(input int lo, input int hi);
        int n;
        int k;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 63);
            if (k < 26)
                cred_buf.push_back(8'(BYTE_UPPER_A + k));
            else if (k < 52)
                cred_buf.push_back(8'(BYTE_LOWER_A + k - 26));
            else if (k < 62)
                cred_buf.push_back(8'(BYTE_DIGIT_0 + k - 52));
            else if (k == 62)
                cred_buf.push_back(BYTE_USCORE);
            else
                cred_buf.push_back(BYTE_DASH);
        end
    endfunction

    function automatic void build_jws();
        int pos;
        cred_buf = {};
        repeat ($urandom_range(0, 3)) push_blank();
        push_segment(1, 6);
        cred_buf.push_back(BYTE_DOT);
        push_segment(1, 6);
        cred_buf.push_back(BYTE_DOT);
        push_segment(0, 6);
        repeat ($urandom_range(0, 3)) push_blank();
        if ($urandom_range(0, 99) < 25) begin
            pos = $urandom_range(0, cred_buf.size() - 1);
            case ($urandom_range(0, 3))
                0:       cred_buf.delete(pos);
                1:       cred_buf.insert(pos, BYTE_LEAD_C2);
                2:       cred_buf.push_back(BYTE_LEAD_C2);
                default: cred_buf[pos] = 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    task automatic test_length_cap();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_long(20);
        wait_drain();
        write_cap(16'd16);
        send_long(16);
        send_long(17);
        wait_drain();
        write_cap(16'd0);
        send_text(" ");
        send_text("a");
        wait_drain();
        write_cap(16'd1);
        send_text("a");
        send_text("ab");
        wait_drain();
        write_cap(16'd5);
        send_text("a.b.c");
        send_text(" a.b.c");
        wait_drain();
        write_cap(16'hFFFF);
        send_long(40);
        wait_drain();
    endtask

    task automatic test_empty_marks();
        src_idle_pct  = 12;
        sink_idle_pct = 46;
        send_tok(8'hFF, 1'b0, 1'b1);
        send_tok(8'h00, 1'b1, 1'b1);
        // empty mark in the middle of a credential
        send_tok("a", 1'b0, 1'b0);
        send_tok("b", 1'b0, 1'b0);
        send_tok(8'h5A, 1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_trim_and_shape();
        cred_buf = {BYTE_HT, BYTE_LEAD_C2, BYTE_NEL};
        send_cred();
        send_text("a.b.");
        cred_buf = {BYTE_LEAD_C2, BYTE_NBSP, "_", BYTE_DOT, "-", BYTE_DOT, "Z", BYTE_CR};
        send_cred();
        send_text("A.9 ");
        wait_drain();
    endtask

    task automatic test_stray_lead_bytes();
        cred_buf = {BYTE_LEAD_C2};
        send_cred();
        cred_buf = {BYTE_NEL};
        send_cred();
        cred_buf = {8'hFF};
        send_cred();
        cred_buf = {"a", BYTE_DOT, "b", BYTE_DOT, BYTE_LEAD_C2};
        send_cred();
        cred_buf = {BYTE_LEAD_C2, "a", BYTE_DOT, "b", BYTE_DOT, "c"};
        send_cred();
        wait_drain();
    endtask

    task automatic test_ready_holdoff();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_cap(MAX_TOKEN_RESET);
        hold_cycles = 300;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 0) begin
                build_jws();
                send_cred();
            end else begin
                send_tok(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
        end
        wait_drain();
    endtask

    task automatic test_random_mix(input int src_pct, input int sink_pct,
                                   input logic [CFG_W-1:0] cap, input int target);
        int start;
        int k;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        write_cap(cap);
        start = tok_sent;
        while (tok_sent - start < target) begin
            k = $urandom_range(0, 99);
            if (k < 65) begin
                build_jws();
                send_cred();
            end else if (k < 75) begin
                cred_buf = {};
                repeat ($urandom_range(1, 4)) push_blank();
                send_cred();
            end else if (k < 82) begin
                send_tok(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else if (k < 88) begin
                repeat ($urandom_range(1, 5))
                    send_tok(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_tok(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                cred_buf = {};
                repeat ($urandom_range(1, 8)) cred_buf.push_back(8'($urandom_range(0, 255)));
                send_cred();
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_cap();
        test_empty_marks();
        test_trim_and_shape();
        test_stray_lead_bytes();
        test_ready_holdoff();
        test_random_mix(12, 46, 16'($urandom_range(10, 24)), 450);
        test_random_mix(46, 12, 16'hFFFF, 450);
        test_random_mix(0, 0, 16'($urandom_range(12, 20)), 450);

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mism_cnt == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
